### src/station_table_linear_interpolator_core_assert.svh
// Concurrent assertion shorthands for the interpolator core.
// Both sample on the rising edge of clock and are disabled while reset is high.
`ifndef STATION_TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define STATION_TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define STLI_ASSERT_HOLD(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("stli: invariant violated");

`define STLI_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("stli: sequence violated");

`else

`define STLI_ASSERT_HOLD(lbl, cond)

`define STLI_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

### src/stli_pkg.sv
package stli_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int DATA_W      = 32;
   localparam int ENTRY_W     = 2 * DATA_W;
   localparam int DIV_STEPS   = DATA_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

### src/stli_ram.sv
module stli_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/station_table_linear_interpolator_core.sv
// Breakpoint table with piecewise linear interpolation. Each request transaction carries an
// operation: clear the table, append one (station, height) breakpoint, or query a station.
// Every request yields exactly one response transaction with a Q23.8 value and a status
// (ok, query out of range, append refused because the table is full). A query walks the
// stored entries in append order through the single read port of the table memory, one
// entry per cycle, until it meets the first station strictly greater than the query, then
// forms the differences, one 32x32 product, and a restoring division that resolves one
// quotient bit per cycle. Clear, append, undefined operations and a query on an empty
// table go from acceptance straight to hand-off. A query that interpolates scans at most
// 256 entries, then passes through acceptance, the scan, the differences, the product,
// the division, the sum and the hand-off in that order. A query found out of range goes
// from the scan straight to hand-off. The request side is busy for the whole transaction;
// a finished response waits in the output register while the next request is accepted,
// and the next result holds in its final cycle until that register is free.
// Entries are not cleared at reset.
module station_table_linear_interpolator_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] station, [63:32] height
   input  logic [1:0]  req_tuser,   // [1:0] op

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DIFF,
      S_MUL,
      S_DIV,
      S_SUM,
      S_DONE
   } state_type;

   localparam int DW = stli_pkg::DATA_W;

   state_type                       state_ff, state_in;
   logic [stli_pkg::COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [stli_pkg::COUNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                            vld_ff, vld_in;
   logic signed [DW-1:0]            q_ff, q_in;
   logic signed [DW-1:0]            s1_ff, s1_in;
   logic signed [DW-1:0]            h1_ff, h1_in;
   logic signed [DW-1:0]            s2_ff, s2_in;
   logic signed [DW-1:0]            h2_ff, h2_in;
   logic [DW-1:0]                   dq_ff, dq_in;
   logic [DW-1:0]                   ds_ff, ds_in;
   logic [DW-1:0]                   mag_ff, mag_in;
   logic                            neg_ff, neg_in;
   logic [DW-1:0]                   rem_ff, rem_in;
   logic [DW-1:0]                   quo_ff, quo_in;
   logic [stli_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [DW-1:0]                   res_value_ff, res_value_in;
   stli_pkg::status_type            res_status_ff, res_status_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [DW-1:0]                   rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]                      rsp_tuser_ff, rsp_tuser_in;

   logic                            req_fire;
   stli_pkg::op_type                req_op;
   logic signed [DW-1:0]            req_station;
   logic signed [DW-1:0]            req_height;

   logic                            ram_wr_en;
   logic [stli_pkg::ADDR_W-1:0]     ram_wr_addr;
   logic [stli_pkg::ENTRY_W-1:0]    ram_wr_data;
   logic                            ram_rd_en;
   logic [stli_pkg::ENTRY_W-1:0]    ram_rd_data;
   logic signed [DW-1:0]            rd_station;
   logic signed [DW-1:0]            rd_height;

   logic signed [DW:0]              dq_wide;
   logic signed [DW:0]              ds_wide;
   logic signed [DW:0]              dh_wide;
   logic signed [DW:0]              dh_abs;
   logic [2*DW-1:0]                 prod;
   logic [DW:0]                     trial;
   logic                            trial_ge;
   logic [DW:0]                     trial_sub;

   assign req_tready  = (state_ff == S_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign req_op      = stli_pkg::op_type'(req_tuser);
   assign req_station = req_tdata[DW-1:0];
   assign req_height  = req_tdata[2*DW-1:DW];

   assign ram_wr_en   = req_fire && (req_op == stli_pkg::OP_APPEND) &&
                        (cnt_ff != stli_pkg::COUNT_W'(stli_pkg::TABLE_DEPTH));
   assign ram_wr_addr = cnt_ff[stli_pkg::ADDR_W-1:0];
   assign ram_wr_data = {req_height, req_station};
   assign ram_rd_en   = (state_ff == S_SCAN);
   assign rd_station  = ram_rd_data[DW-1:0];
   assign rd_height   = ram_rd_data[2*DW-1:DW];

   stli_ram #(
      .WIDTH (stli_pkg::ENTRY_W),
      .DEPTH (stli_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[stli_pkg::ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign dq_wide   = {q_ff[DW-1], q_ff} - {s1_ff[DW-1], s1_ff};
   assign ds_wide   = {s2_ff[DW-1], s2_ff} - {s1_ff[DW-1], s1_ff};
   assign dh_wide   = {h2_ff[DW-1], h2_ff} - {h1_ff[DW-1], h1_ff};
   assign dh_abs    = dh_wide[DW] ? -dh_wide : dh_wide;
   assign prod      = (2*DW)'(dq_ff) * (2*DW)'(mag_ff);
   assign trial     = {rem_ff, quo_ff[DW-1]};
   assign trial_ge  = (trial >= {1'b0, ds_ff});
   assign trial_sub = trial - {1'b0, ds_ff};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      vld_in        = vld_ff;
      q_in          = q_ff;
      s1_in         = s1_ff;
      h1_in         = h1_ff;
      s2_in         = s2_ff;
      h2_in         = h2_ff;
      dq_in         = dq_ff;
      ds_in         = ds_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_value_in  = '0;
               res_status_in = stli_pkg::ST_OK;
               state_in      = S_DONE;
               case (req_op)
                  stli_pkg::OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  stli_pkg::OP_APPEND: begin
                     if (cnt_ff == stli_pkg::COUNT_W'(stli_pkg::TABLE_DEPTH)) begin
                        res_status_in = stli_pkg::ST_FULL;
                     end else begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  stli_pkg::OP_QUERY: begin
                     q_in = req_station;
                     if (cnt_ff == '0) begin
                        res_status_in = stli_pkg::ST_RANGE;
                     end else begin
                        rd_idx_in = '0;
                        vld_in    = 1'b0;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            vld_in    = 1'b1;
            if (vld_ff) begin
               if (rd_station > q_ff) begin
                  if (rd_idx_ff == stli_pkg::COUNT_W'(1)) begin
                     res_status_in = stli_pkg::ST_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     s2_in    = rd_station;
                     h2_in    = rd_height;
                     state_in = S_DIFF;
                  end
               end else begin
                  s1_in = rd_station;
                  h1_in = rd_height;
                  if (rd_idx_ff == cnt_ff) begin
                     res_status_in = stli_pkg::ST_RANGE;
                     state_in      = S_DONE;
                  end
               end
            end
         end
         S_DIFF: begin
            dq_in    = dq_wide[DW-1:0];
            ds_in    = ds_wide[DW-1:0];
            neg_in   = dh_wide[DW];
            mag_in   = dh_abs[DW-1:0];
            state_in = S_MUL;
         end
         S_MUL: begin
            rem_in   = prod[2*DW-1:DW];
            quo_in   = prod[DW-1:0];
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
            quo_in  = {quo_ff[DW-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == stli_pkg::STEP_W'(stli_pkg::DIV_STEPS - 1)) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            res_value_in  = neg_ff ? (h1_ff - quo_ff) : (h1_ff + quo_ff);
            res_status_in = stli_pkg::ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_value_ff;
               rsp_tuser_in  = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      vld_ff        <= vld_in;
      q_ff          <= q_in;
      s1_ff         <= s1_in;
      h1_ff         <= h1_in;
      s2_ff         <= s2_in;
      h2_ff         <= h2_in;
      dq_ff         <= dq_in;
      ds_ff         <= ds_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`include "station_table_linear_interpolator_core_assert.svh"

   `STLI_ASSERT_HOLD(a_div_rem_below_divisor, (state_ff != S_DIV) || (rem_ff < ds_ff))
   `STLI_ASSERT_HOLD(a_scan_within_count, (state_ff != S_SCAN) || (rd_idx_ff <= cnt_ff))
   `STLI_ASSERT_HOLD(a_value_zero_unless_ok,
      !rsp_tvalid || (rsp_tuser == stli_pkg::ST_OK) || (rsp_tdata == '0))
   `STLI_ASSERT_NEXT(a_full_append_keeps_count,
      req_fire && (req_op == stli_pkg::OP_APPEND) &&
      (cnt_ff == stli_pkg::COUNT_W'(stli_pkg::TABLE_DEPTH)),
      (cnt_ff == stli_pkg::COUNT_W'(stli_pkg::TABLE_DEPTH)) &&
      (res_status_ff == stli_pkg::ST_FULL))

endmodule

### tb/station_table_linear_interpolator_core_test.sv
`timescale 1ns / 100ps

module station_table_linear_interpolator_core_test;

   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam logic [31:0] STN_MIN = 32'h8000_0000;
   localparam logic [31:0] STN_MAX = 32'h7FFF_FFFF;
   localparam int ITEM_GOAL = 1200;
   localparam int HOLDOFF_CYCLES = 400;

   typedef struct packed {
      logic [31:0]          value;
      stli_pkg::status_type status;
   } answer_type;

   typedef struct {
      logic [1:0]           op;
      logic [31:0]          stn;
      logic [31:0]          hgt;
      bit                   typed;
      logic [31:0]          value;
      stli_pkg::status_type status;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] station, [63:32] height
   logic [1:0]  req_tuser;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] value
   logic [1:0]  rsp_tuser;   // [1:0] status

   logic signed [31:0] stn_tbl [stli_pkg::TABLE_DEPTH];
   logic signed [31:0] hgt_tbl [stli_pkg::TABLE_DEPTH];
   int                 entry_total = 0;

   answer_type pending_answers[$];
   int         fault_count = 0;
   int         items_sent = 0;
   int         burst_left = 0;
   bit         holdoff_request = 1'b0;
   int         holdoff_left = 0;
   int         ready_pct = 100;
   int         phase_left = 0;
   int         session;

   vector_type directed [19] = '{
      '{stli_pkg::OP_QUERY,  0,           0,       1, 0,       stli_pkg::ST_RANGE},
      '{stli_pkg::OP_APPEND, STN_MIN,     STN_MIN, 1, 0,       stli_pkg::ST_OK},
      '{stli_pkg::OP_QUERY,  STN_MIN,     STN_MAX, 1, 0,       stli_pkg::ST_RANGE},
      '{stli_pkg::OP_APPEND, STN_MAX,     STN_MAX, 1, 0,       stli_pkg::ST_OK},
      '{stli_pkg::OP_QUERY,  STN_MIN,     0,       1, STN_MIN, stli_pkg::ST_OK},
      '{stli_pkg::OP_QUERY,  STN_MAX,     0,       1, 0,       stli_pkg::ST_RANGE},
      '{stli_pkg::OP_QUERY,  0,           -1,      0, 0,       stli_pkg::ST_OK},
      '{stli_pkg::OP_QUERY,  STN_MAX - 1, 0,       0, 0,       stli_pkg::ST_OK},
      '{OP_UNDEFINED,        STN_MAX,     STN_MIN, 1, 0,       stli_pkg::ST_OK},
      '{stli_pkg::OP_CLEAR,  -1,          -1,      1, 0,       stli_pkg::ST_OK},
      '{stli_pkg::OP_QUERY,  5,           0,       1, 0,       stli_pkg::ST_RANGE},
      '{stli_pkg::OP_APPEND, 100,         0,       1, 0,       stli_pkg::ST_OK},
      '{stli_pkg::OP_QUERY,  50,          0,       1, 0,       stli_pkg::ST_RANGE},
      '{stli_pkg::OP_APPEND, 200,         -999,    1, 0,       stli_pkg::ST_OK},
      '{stli_pkg::OP_APPEND, 50,          5000,    1, 0,       stli_pkg::ST_OK},
      '{stli_pkg::OP_QUERY,  133,         0,       0, 0,       stli_pkg::ST_OK},
      '{stli_pkg::OP_QUERY,  60,          0,       1, 0,       stli_pkg::ST_RANGE},
      '{stli_pkg::OP_QUERY,  300,         0,       1, 0,       stli_pkg::ST_RANGE},
      '{stli_pkg::OP_QUERY,  199,         0,       0, 0,       stli_pkg::ST_OK}
   };

   station_table_linear_interpolator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic answer_type lerp_predict(input logic [1:0] op,
                                               input logic signed [31:0] stn,
                                               input logic signed [31:0] hgt);
      answer_type a;
      int         found;
      int         i;
      longint     q, s1, s2, h1, h2, d, v;
      bit [63:0]  dq, ds, mag, quo;
      a.value = '0;
      a.status = stli_pkg::ST_OK;
      found = -1;
      case (op)
         stli_pkg::OP_CLEAR: entry_total = 0;
         stli_pkg::OP_APPEND: begin
            if (entry_total >= stli_pkg::TABLE_DEPTH) begin
               a.status = stli_pkg::ST_FULL;
            end else begin
               stn_tbl[entry_total] = stn;
               hgt_tbl[entry_total] = hgt;
               entry_total++;
            end
         end
         stli_pkg::OP_QUERY: begin
            for (i = 0; i < entry_total; i++)
               if (found < 0 && stn_tbl[i] > stn) found = i;
            if (found <= 0) begin
               a.status = stli_pkg::ST_RANGE;
            end else begin
               q = stn;
               s1 = stn_tbl[found - 1];
               s2 = stn_tbl[found];
               h1 = hgt_tbl[found - 1];
               h2 = hgt_tbl[found];
               dq = q - s1;
               ds = s2 - s1;
               d = h2 - h1;
               mag = (d < 0) ? -d : d;
               quo = (dq * mag) / ds;
               v = (d < 0) ? h1 - longint'(quo) : h1 + longint'(quo);
               a.value = v[31:0];
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [31:0] stn,
                            input logic [31:0] hgt, input bit typed = 1'b0,
                            input answer_type fixed = '0);
      int         gap;
      answer_type a;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {hgt, stn};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      a = lerp_predict(op, stn, hgt);
      pending_answers.push_back(typed ? fixed : a);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic table_session(input int idx);
      int          stations[$];
      int          n, span, base, queries, k, j, sel;
      longint      gap;
      bit [63:0]   r;
      logic [31:0] q, h;
      if (idx == 0 || idx == 20) n = stli_pkg::TABLE_DEPTH + $urandom_range(1, 3);
      else if (idx == 2) n = 12;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(13, 60);
      else n = $urandom_range(0, 12);
      span = $urandom_range(0, 2);
      base = $urandom;
      for (k = 0; k < n; k++)
         case (span)
            0: stations.push_back($urandom);
            1: stations.push_back(base + $urandom_range(0, 5000));
            default: stations.push_back($urandom_range(0, 40) - 20);
         endcase
      if ($urandom_range(0, 6) != 0) stations.sort();
      if ($urandom_range(0, 9) != 0 || n > stli_pkg::TABLE_DEPTH)
         send_item(stli_pkg::OP_CLEAR, $urandom, $urandom);
      foreach (stations[i]) begin
         h = (span == 0 || $urandom_range(0, 1)) ? $urandom : $urandom_range(0, 4000) - 2000;
         send_item(stli_pkg::OP_APPEND, stations[i], h);
      end
      queries = (n > 100) ? 4 : $urandom_range(1, 10);
      for (k = 0; k < queries; k++) begin
         sel = $urandom_range(0, 9);
         q = $urandom;
         if (sel <= 4 && n >= 2) begin
            j = $urandom_range(0, n - 2);
            gap = longint'(stations[j + 1]) - longint'(stations[j]);
            r = {$urandom, $urandom};
            q = (gap > 0) ? stations[j] + (r % gap) : stations[j];
         end else if (sel <= 6 && n >= 1) begin
            q = stations[$urandom_range(0, n - 1)];
         end else if (sel == 7) begin
            case ($urandom_range(0, 2))
               0: q = STN_MIN;
               1: q = STN_MAX;
               default: q = 0;
            endcase
         end
         send_item(stli_pkg::OP_QUERY, q, $urandom);
         if ($urandom_range(0, 7) == 0) send_item(OP_UNDEFINED, $urandom, $urandom);
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response value %h status %0d", $time, rsp_tdata,
                     rsp_tuser);
            fault_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata !== want.value) begin
               $display("%0t: value mismatch, expected %h actual %h", $time, want.value,
                        rsp_tdata);
               fault_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d", $time,
                        want.status, rsp_tuser);
               fault_count++;
            end
         end
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else if (holdoff_request) begin
         holdoff_request = 1'b0;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0: ready_pct = 100;
               1: ready_pct = 70;
               default: ready_pct = 25;
            endcase
            phase_left = $urandom_range(20, 300);
         end
         phase_left--;
         rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= stli_pkg::OP_CLEAR;
      rsp_tready <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_item(directed[i].op, directed[i].stn, directed[i].hgt, directed[i].typed,
                   '{directed[i].value, directed[i].status});
      session = 0;
      while (items_sent < ITEM_GOAL) begin
         if (session == 2) holdoff_request = 1'b1;
         table_session(session);
         if (session % 5 == 4) wait_drained();
         session++;
      end
      wait_drained();
      repeat (60) @(posedge clock);
      if (fault_count == 0)
         $display("station_table_linear_interpolator_core test passed");
      else
         $display("station_table_linear_interpolator_core test failed");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("station_table_linear_interpolator_core test failed");
      $finish;
   end

endmodule
